### rtl/glyph_point_delta_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Glyph point delta encoder: assertion macros
// Short forms for the clocked, reset-qualified assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef GLYPH_POINT_DELTA_ENCODER_UNIT_MACROS_SVH
`define GLYPH_POINT_DELTA_ENCODER_UNIT_MACROS_SVH

// A property checked at every rising clock edge while reset is released.
`define GPDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal that must keep its value in the cycle after a condition holds.
`define GPDE_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

### rtl/gpde_pkg.sv
// ----------------------------------------------------------------------------
// Glyph point delta encoder: package
// Stream tags, flag bits and the byte bundle passed from encoder to serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package gpde_pkg;

    // Largest number of output beats a single point can cause.
    localparam int MAX_BEATS = 7;
    localparam int CNT_W     = $clog2(MAX_BEATS + 1);
    localparam int IDX_W     = $clog2(MAX_BEATS);

    // Flag byte bits.
    localparam logic [7:0] FL_ON     = 8'h01;
    localparam logic [7:0] FL_XSHORT = 8'h02;
    localparam logic [7:0] FL_YSHORT = 8'h04;
    localparam logic [7:0] FL_REPEAT = 8'h08;
    localparam logic [7:0] FL_XSAME  = 8'h10;
    localparam logic [7:0] FL_YSAME  = 8'h20;

    // Longest run of repeats a single flag may carry.
    localparam logic [7:0] RUN_CAP = 8'hFE;

    // Delta ranges that fit in one magnitude byte.
    localparam logic [15:0] SHORT_POS_MAX = 16'h00FF;
    localparam logic [15:0] SHORT_NEG_MIN = 16'hFF01;

    typedef enum logic [1:0] {
        TAG_FLAG = 2'd0,
        TAG_X    = 2'd1,
        TAG_Y    = 2'd2
    } gpde_tag_t;

    // One output beat.
    typedef struct packed {
        gpde_tag_t  tag;
        logic [7:0] data;
    } gpde_beat_t;

    // All beats caused by one point.
    typedef struct packed {
        gpde_beat_t [MAX_BEATS-1:0] beats;
        logic [CNT_W-1:0]           count;
        logic                       glyph_last;
    } gpde_bundle_t;

endpackage

`default_nettype wire

### rtl/glyph_point_delta_encoder_unit.sv
// ----------------------------------------------------------------------------
// Glyph point delta encoder unit
// Encodes outline points into run-length packed flag bytes and x and y
// coordinate delta bytes, one tagged byte per output beat.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  point   | pt_valid / pt_stall   | x_coord, y_coord, on_curve, glyph_last
//  byte    | byte_valid/byte_stall | stream_tag, data_byte, item_last, glyph_done
//
//  A point is held in the encoder input register, then its 0 to 7 bytes
//  leave the serializer one byte per cycle while byte_stall is low; a new
//  point waits until the serializer can take the held point's bytes.
//  First byte passes the input, bundle and output registers in turn.
//  Reset clears the coder state and all valid flags; no clearing pass.
//  An output stall holds the output register and backs up to pt_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_point_delta_encoder_unit
    import gpde_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pt_valid,
    output logic                     pt_stall,
    input  wire logic signed [15:0]  x_coord,
    input  wire logic signed [15:0]  y_coord,
    input  wire logic                on_curve,
    input  wire logic                glyph_last,
    output logic                     byte_valid,
    input  wire logic                byte_stall,
    output logic [1:0]               stream_tag,
    output logic [7:0]               data_byte,
    output logic                     item_last,
    output logic                     glyph_done
);

    logic         enc_adv;
    logic         bun_free;
    gpde_bundle_t enc_bundle;

    gpde_encoder u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_valid   (pt_valid),
        .pt_stall   (pt_stall),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .on_curve   (on_curve),
        .glyph_last (glyph_last),
        .bun_free   (bun_free),
        .enc_adv    (enc_adv),
        .enc_bundle (enc_bundle)
    );

    gpde_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .enc_adv    (enc_adv),
        .enc_bundle (enc_bundle),
        .bun_free   (bun_free),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .stream_tag (stream_tag),
        .data_byte  (data_byte),
        .item_last  (item_last),
        .glyph_done (glyph_done)
    );

endmodule

`default_nettype wire

### rtl/gpde_encoder.sv
// ----------------------------------------------------------------------------
// Glyph point delta encoder: encoder stage
// Registers the incoming point, forms deltas and the flag, runs the flag
// run-length packer and builds the list of bytes the point causes.
// ----------------------------------------------------------------------------
`default_nettype none

module gpde_encoder
    import gpde_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pt_valid,
    output logic                     pt_stall,
    input  wire logic signed [15:0]  x_coord,
    input  wire logic signed [15:0]  y_coord,
    input  wire logic                on_curve,
    input  wire logic                glyph_last,
    input  wire logic                bun_free,
    output logic                     enc_adv,
    output gpde_bundle_t             enc_bundle
);

    typedef struct packed {
        logic       short_bit;
        logic       same_bit;
        logic [1:0] nbytes;
        logic [7:0] b0;
        logic [7:0] b1;
    } gpde_delta_t;

    // Classifies one wrapped delta into flag bits and stream bytes.
    function automatic gpde_delta_t code_delta(input logic [15:0] d);
        gpde_delta_t r;
        logic [15:0] neg;
        neg = 16'd0 - d;
        r   = '0;
        if (d == 16'd0) begin
            r.same_bit = 1'b1;
        end else if (d <= SHORT_POS_MAX) begin
            r.short_bit = 1'b1;
            r.same_bit  = 1'b1;
            r.nbytes    = 2'd1;
            r.b0        = d[7:0];
        end else if (d >= SHORT_NEG_MIN) begin
            r.short_bit = 1'b1;
            r.nbytes    = 2'd1;
            r.b0        = neg[7:0];
        end else begin
            r.nbytes = 2'd2;
            r.b0     = d[15:8];
            r.b1     = d[7:0];
        end
        return r;
    endfunction

    logic        in_valid_reg;
    logic [15:0] in_x_reg;
    logic [15:0] in_y_reg;
    logic        in_on_reg;
    logic        in_last_reg;

    logic [15:0] prev_x_reg;
    logic [15:0] prev_y_reg;
    logic [7:0]  pend_flag_reg;
    logic        pend_valid_reg;
    logic [7:0]  run_reg;

    logic [15:0] prev_x_next;
    logic [15:0] prev_y_next;
    logic [7:0]  pend_flag_next;
    logic        pend_valid_next;
    logic [7:0]  run_next;

    gpde_delta_t dx_code;
    gpde_delta_t dy_code;
    logic [7:0]  flag;
    logic        extend;
    logic        pt_take;
    logic [7:0]  run_inc;
    gpde_beat_t [MAX_BEATS-1:0] beats;
    logic [CNT_W-1:0]           n;

    // The input register moves on when the bundle register can take its bytes.
    assign enc_adv  = in_valid_reg && bun_free;
    assign pt_stall = in_valid_reg && !enc_adv;
    assign pt_take  = pt_valid && !pt_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (pt_take) begin
            in_valid_reg <= 1'b1;
        end else if (enc_adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (pt_take) begin
            in_x_reg    <= x_coord;
            in_y_reg    <= y_coord;
            in_on_reg   <= on_curve;
            in_last_reg <= glyph_last;
        end
    end

    // Deltas and flag byte.
    assign dx_code = code_delta(in_x_reg - prev_x_reg);
    assign dy_code = code_delta(in_y_reg - prev_y_reg);
    assign flag    = (in_on_reg         ? FL_ON     : 8'h00)
                   | (dx_code.short_bit ? FL_XSHORT : 8'h00)
                   | (dy_code.short_bit ? FL_YSHORT : 8'h00)
                   | (dx_code.same_bit  ? FL_XSAME  : 8'h00)
                   | (dy_code.same_bit  ? FL_YSAME  : 8'h00);
    assign extend  = pend_valid_reg && (flag == pend_flag_reg) && (run_reg < RUN_CAP);
    assign run_inc = run_reg + 8'd1;

    // Byte list: closing of the old run, x bytes, y bytes, flush at glyph end.
    always_comb begin
        beats = '0;
        n     = '0;
        if (!extend && pend_valid_reg) begin
            if (run_reg != 8'd0) begin
                beats[n] = '{tag: TAG_FLAG, data: pend_flag_reg | FL_REPEAT};
                n        = n + 1'b1;
                beats[n] = '{tag: TAG_FLAG, data: run_reg};
                n        = n + 1'b1;
            end else begin
                beats[n] = '{tag: TAG_FLAG, data: pend_flag_reg};
                n        = n + 1'b1;
            end
        end
        if (dx_code.nbytes != 2'd0) begin
            beats[n] = '{tag: TAG_X, data: dx_code.b0};
            n        = n + 1'b1;
        end
        if (dx_code.nbytes == 2'd2) begin
            beats[n] = '{tag: TAG_X, data: dx_code.b1};
            n        = n + 1'b1;
        end
        if (dy_code.nbytes != 2'd0) begin
            beats[n] = '{tag: TAG_Y, data: dy_code.b0};
            n        = n + 1'b1;
        end
        if (dy_code.nbytes == 2'd2) begin
            beats[n] = '{tag: TAG_Y, data: dy_code.b1};
            n        = n + 1'b1;
        end
        if (in_last_reg) begin
            if (extend) begin
                beats[n] = '{tag: TAG_FLAG, data: pend_flag_reg | FL_REPEAT};
                n        = n + 1'b1;
                beats[n] = '{tag: TAG_FLAG, data: run_inc};
                n        = n + 1'b1;
            end else begin
                beats[n] = '{tag: TAG_FLAG, data: flag};
                n        = n + 1'b1;
            end
        end
    end

    assign enc_bundle = '{beats: beats, count: n, glyph_last: in_last_reg};

    // Next coder state: a glyph end returns everything to zero.
    always_comb begin
        prev_x_next     = in_x_reg;
        prev_y_next     = in_y_reg;
        pend_flag_next  = flag;
        pend_valid_next = 1'b1;
        run_next        = 8'd0;
        if (extend) begin
            pend_flag_next = pend_flag_reg;
            run_next       = run_inc;
        end
        if (in_last_reg) begin
            prev_x_next     = 16'd0;
            prev_y_next     = 16'd0;
            pend_flag_next  = 8'd0;
            pend_valid_next = 1'b0;
            run_next        = 8'd0;
        end
    end

    // Coder state registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_x_reg     <= 16'd0;
            prev_y_reg     <= 16'd0;
            pend_flag_reg  <= 8'd0;
            pend_valid_reg <= 1'b0;
            run_reg        <= 8'd0;
        end else if (enc_adv) begin
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            pend_flag_reg  <= pend_flag_next;
            pend_valid_reg <= pend_valid_next;
            run_reg        <= run_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gpde_serializer.sv
// ----------------------------------------------------------------------------
// Glyph point delta encoder: serializer
// Holds the byte list of one point and hands it out one beat per cycle
// through the output register while byte_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module gpde_serializer
    import gpde_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         enc_adv,
    input  wire gpde_bundle_t enc_bundle,
    output logic              bun_free,
    output logic              byte_valid,
    input  wire logic         byte_stall,
    output logic [1:0]        stream_tag,
    output logic [7:0]        data_byte,
    output logic              item_last,
    output logic              glyph_done
);

    gpde_bundle_t     bun_reg;
    logic             bun_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    gpde_beat_t       out_beat_reg;
    logic             out_last_reg;
    logic             out_done_reg;

    logic             out_free;
    logic             load;
    logic             at_end;
    logic             bun_done;
    gpde_beat_t       cur_beat;

    // Handshake between the bundle register and the output register.
    assign out_free = !out_valid_reg || !byte_stall;
    assign load     = bun_valid_reg && out_free;
    assign at_end   = (CNT_W'(idx_reg) == (bun_reg.count - 1'b1));
    assign bun_done = load && at_end;
    assign bun_free = !bun_valid_reg || bun_done;
    assign cur_beat = bun_reg.beats[idx_reg];

    // Bundle register and beat index.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bun_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (enc_adv) begin
            bun_valid_reg <= (enc_bundle.count != '0);
            idx_reg       <= '0;
        end else if (bun_done) begin
            bun_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (load) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (enc_adv) begin
            bun_reg <= enc_bundle;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= load;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            out_beat_reg <= cur_beat;
            out_last_reg <= at_end;
            out_done_reg <= at_end && bun_reg.glyph_last;
        end
    end

    assign byte_valid = out_valid_reg;
    assign stream_tag = out_beat_reg.tag;
    assign data_byte  = out_beat_reg.data;
    assign item_last  = out_last_reg;
    assign glyph_done = out_done_reg;

endmodule

`default_nettype wire

### rtl/gpde_checker.sv
// ----------------------------------------------------------------------------
// Glyph point delta encoder: port checker
// Watches the top level's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_point_delta_encoder_unit_macros.svh"

module gpde_checker
    import gpde_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pt_valid,
    input wire logic               pt_stall,
    input wire logic signed [15:0] x_coord,
    input wire logic signed [15:0] y_coord,
    input wire logic               on_curve,
    input wire logic               glyph_last,
    input wire logic               byte_valid,
    input wire logic               byte_stall,
    input wire logic [1:0]         stream_tag,
    input wire logic [7:0]         data_byte,
    input wire logic               item_last,
    input wire logic               glyph_done
);

    // A stalled point beat keeps its payload.
    `GPDE_ASSERT_HOLD(a_point_hold, clk, rst_n, pt_valid && pt_stall, {x_coord, y_coord, on_curve, glyph_last}, "stalled point changed")

    // A stalled output beat keeps its byte.
    `GPDE_ASSERT_HOLD(a_byte_hold, clk, rst_n, byte_valid && byte_stall, data_byte, "stalled byte changed")

    // The glyph end mark only rides on the last byte of a point.
    `GPDE_ASSERT(a_done_last, clk, rst_n, byte_valid && glyph_done |-> item_last, "glyph_done without item_last")

    // Only the three defined streams appear.
    `GPDE_ASSERT(a_tag_range, clk, rst_n, byte_valid |-> stream_tag != 2'd3, "undefined stream tag")

    // Bytes of one point leave without gaps.
    `GPDE_ASSERT(a_no_gap, clk, rst_n, byte_valid && !byte_stall && !item_last |=> byte_valid, "gap inside a point")

endmodule

bind glyph_point_delta_encoder_unit gpde_checker u_gpde_checker (.*);

`default_nettype wire
